// File: rtl/assert_macros.svh
// Assertion macros used by the lexer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define KCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define KCL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/kcl_pkg.sv
// Package with types, token codes and the keyword table of the lexer.
`timescale 1ns / 1ps
package kcl_pkg;

  localparam int MAX_TOKEN_CHARS = 63;
  localparam int AddrW = $clog2(MAX_TOKEN_CHARS);
  localparam int LenW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int KwMax = 10;
  localparam int KwCount = 34;

  localparam logic [5:0] K_ERROR = 6'd0;
  localparam logic [5:0] K_END = 6'd1;
  localparam logic [5:0] K_EQUALS = 6'd2;
  localparam logic [5:0] K_COLON = 6'd3;
  localparam logic [5:0] K_INTEGER = 6'd4;
  localparam logic [5:0] K_STRING = 6'd5;

  localparam logic [8*KwMax-1:0] KW_WORD [KwCount] = '{
    "MENU", "FORM", "TITLE", "LABEL", "OUTPUT", "TYPE", "WIDTH", {"MAX", "_VALUES"},
    {"MIN", "_VALUES"}, "REQUIRE", "FLOOR", "CEILING", "PATTERN", "ECHO", "FIND", "EDIT",
    "CONSTANT", "VERIFY", "LIST", "TEXT", "INTEGER", "FLOAT", "BOOLEAN", "TRUE",
    "FALSE", "ON", "OFF", "YES", "NO", "NULL", "NONE", "VALUE", "FIELD", "ITEM"
  };

  localparam logic [5:0] KW_KIND [KwCount] = '{
    6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd29, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd31, 6'd31, 6'd32, 6'd33, 6'd34
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic        has_byte;
    logic [7:0]  text_byte;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        last;
  } out_t;

  typedef struct packed {
    logic             append;
    logic             clr_len;
    logic             set_start;
    logic             adv;
    logic             reset_pos;
    logic             capture;
    logic             col_cur;
    logic             out_load;
    logic [5:0]       out_kind;
    logic             out_text;
    logic             out_last;
    logic [AddrW-1:0] rd_addr;
  } cmd_t;

  typedef struct packed {
    logic            eoi;
    logic            sp;
    logic            dig;
    logic            alp;
    logic            us;
    logic            prt;
    logic            quo;
    logic            hash;
    logic            eq;
    logic            colon;
    logic            nl;
    logic            full;
    logic [5:0]      kw_kind;
    logic [LenW-1:0] emit_len;
  } sts_t;

  // Returns the keyword kind of a right-aligned, zero-filled word, or zero.
  function automatic logic [5:0] kw_lookup(logic [8*KwMax-1:0] word, logic [LenW-1:0] len);
    logic [5:0] kind;
    kind = K_ERROR;
    for (int e = 0; e < KwCount; e++) begin
      if (word == KW_WORD[e] && len <= LenW'(KwMax)) begin
        kind = kind | KW_KIND[e];
      end
    end
    return kind;
  endfunction

endpackage

// File: rtl/kcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kcl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/kcl_datapath.sv
// Datapath of the lexer: position counters, token text store and result register.
`timescale 1ns / 1ps
module kcl_datapath import kcl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_data_i,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  output out_t  out_data_o
);

  logic [15:0]          line_q, line_d, col_q, col_d, start_q, start_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [8*KwMax-1:0]   kwbuf_q, kwbuf_d;
  logic [15:0]          emit_line_q, emit_col_q;
  logic [LenW-1:0]      emit_len_q;
  out_t                 out_q;
  logic [7:0]           ch, uc, rdata;

  assign ch = in_data_i.data_byte;
  assign uc = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;

  always_comb begin
    sts_o.eoi = in_data_i.req_type;
    sts_o.sp = ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
    sts_o.dig = ch >= 8'h30 && ch <= 8'h39;
    sts_o.alp = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    sts_o.us = ch == 8'h5F;
    sts_o.prt = ch >= 8'h20 && ch <= 8'h7E;
    sts_o.quo = ch == 8'h27;
    sts_o.hash = ch == 8'h23;
    sts_o.eq = ch == 8'h3D;
    sts_o.colon = ch == 8'h3A;
    sts_o.nl = ch == 8'h0A;
    sts_o.full = len_q >= LenW'(MAX_TOKEN_CHARS);
    sts_o.kw_kind = kw_lookup(kwbuf_q, len_q);
    sts_o.emit_len = emit_len_q;
  end

  kcl_ram #(
    .Width(8),
    .Depth(MAX_TOKEN_CHARS)
  ) u_text (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (len_q[AddrW-1:0]),
    .wdata_i (ch),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    line_d = line_q;
    col_d = col_q;
    start_d = start_q;
    len_d = len_q;
    kwbuf_d = kwbuf_q;
    if (cmd_i.append) begin
      len_d = len_q + 1'b1;
      kwbuf_d = (len_q == '0) ? {{(8*KwMax-8){1'b0}}, uc} : {kwbuf_q[8*KwMax-9:0], uc};
    end
    if (cmd_i.clr_len) begin
      len_d = '0;
    end
    if (cmd_i.set_start) begin
      start_d = col_q;
    end
    if (cmd_i.adv) begin
      if (sts_o.nl) begin
        if (line_q != 16'hFFFF) begin
          line_d = line_q + 16'd1;
        end
        col_d = 16'd1;
      end else if (col_q != 16'hFFFF) begin
        col_d = col_q + 16'd1;
      end
    end
    if (cmd_i.reset_pos) begin
      line_d = 16'd1;
      col_d = 16'd1;
      start_d = 16'd1;
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= 16'd1;
      col_q <= 16'd1;
      start_q <= 16'd1;
      len_q <= '0;
    end else begin
      line_q <= line_d;
      col_q <= col_d;
      start_q <= start_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kwbuf_q <= kwbuf_d;
    if (cmd_i.capture) begin
      emit_line_q <= line_q;
      emit_col_q <= cmd_i.col_cur ? col_q : start_q;
      emit_len_q <= len_q;
    end
    if (cmd_i.out_load) begin
      out_q.token_kind <= cmd_i.out_kind;
      out_q.has_byte <= cmd_i.out_text;
      out_q.text_byte <= cmd_i.out_text ? rdata : 8'd0;
      out_q.token_line <= emit_line_q;
      out_q.token_column <= emit_col_q;
      out_q.last <= cmd_i.out_last;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/kcl_ctrl.sv
// Controller of the lexer: lexer mode, result sequencing and output handshake.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kcl_ctrl import kcl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    MD_START, MD_COMMENT, MD_INTEGER, MD_WORD, MD_STRING, MD_QUOTE, MD_ERR
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TXT_RD, ST_TXT_WR, ST_S1, ST_S2
  } state_e;

  mode_e            mode_q, mode_d;
  state_e           state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             t_en_q, t_en_d, s1_en_q, s1_en_d, s2_en_q, s2_en_d;
  logic [5:0]       t_kind_q, t_kind_d, s1_kind_q, s1_kind_d, s2_kind_q, s2_kind_d;
  logic             accept, ofree, fail, eq_start, tlast;
  cmd_t             cmd;

  assign accept = in_valid_i && state_q == ST_IDLE;
  assign ofree = !out_valid_q || out_ready_i;
  assign tlast = sts_i.emit_len == '0 || LenW'(idx_q) + 1'b1 == sts_i.emit_len;

  always_comb begin
    cmd = '0;
    cmd.rd_addr = idx_q;
    mode_d = mode_q;
    state_d = state_q;
    idx_d = idx_q;
    t_en_d = t_en_q;
    t_kind_d = t_kind_q;
    s1_en_d = s1_en_q;
    s1_kind_d = s1_kind_q;
    s2_en_d = s2_en_q;
    s2_kind_d = s2_kind_q;
    fail = 1'b0;
    eq_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_q != MD_ERR) begin
          t_en_d = 1'b0;
          s1_en_d = 1'b0;
          s2_en_d = 1'b0;
          idx_d = '0;
          if (sts_i.eoi) begin
            case (mode_q)
              MD_QUOTE, MD_INTEGER: begin
                t_en_d = 1'b1;
                t_kind_d = (mode_q == MD_QUOTE) ? K_STRING : K_INTEGER;
                s1_en_d = 1'b1;
                s1_kind_d = K_END;
              end
              MD_WORD: begin
                fail = sts_i.kw_kind == K_ERROR;
                s1_en_d = 1'b1;
                s1_kind_d = sts_i.kw_kind;
                s2_en_d = 1'b1;
                s2_kind_d = K_END;
              end
              MD_STRING: fail = 1'b1;
              default: begin
                s1_en_d = 1'b1;
                s1_kind_d = K_END;
              end
            endcase
            cmd.reset_pos = 1'b1;
            mode_d = MD_START;
          end else begin
            case (mode_q)
              MD_START: begin
                if (sts_i.sp) begin
                  mode_d = MD_START;
                end else if (sts_i.hash) begin
                  mode_d = MD_COMMENT;
                end else if (sts_i.dig || sts_i.alp || sts_i.us) begin
                  fail = sts_i.full;
                  cmd.append = 1'b1;
                  cmd.set_start = 1'b1;
                  mode_d = sts_i.dig ? MD_INTEGER : MD_WORD;
                end else if (sts_i.quo) begin
                  cmd.set_start = 1'b1;
                  cmd.clr_len = 1'b1;
                  mode_d = MD_STRING;
                end else if (sts_i.eq) begin
                  cmd.set_start = 1'b1;
                  eq_start = 1'b1;
                  s1_en_d = 1'b1;
                  s1_kind_d = K_EQUALS;
                end else begin
                  fail = 1'b1;
                end
              end
              MD_INTEGER: begin
                if (sts_i.dig) begin
                  fail = sts_i.full;
                  cmd.append = 1'b1;
                end else if (sts_i.sp) begin
                  t_en_d = 1'b1;
                  t_kind_d = K_INTEGER;
                  cmd.clr_len = 1'b1;
                  mode_d = MD_START;
                end else begin
                  fail = 1'b1;
                end
              end
              MD_WORD: begin
                if (sts_i.dig || sts_i.alp || sts_i.us) begin
                  fail = sts_i.full;
                  cmd.append = 1'b1;
                end else if (sts_i.sp || sts_i.colon || sts_i.eq) begin
                  fail = sts_i.kw_kind == K_ERROR;
                  s1_en_d = 1'b1;
                  s1_kind_d = sts_i.kw_kind;
                  s2_en_d = sts_i.colon || sts_i.eq;
                  s2_kind_d = sts_i.colon ? K_COLON : K_EQUALS;
                  cmd.clr_len = 1'b1;
                  mode_d = MD_START;
                end else begin
                  fail = 1'b1;
                end
              end
              MD_COMMENT: begin
                if (sts_i.nl) begin
                  mode_d = MD_START;
                end else begin
                  fail = !sts_i.prt;
                end
              end
              MD_STRING: begin
                if (sts_i.quo) begin
                  mode_d = MD_QUOTE;
                end else if (sts_i.prt) begin
                  fail = sts_i.full;
                  cmd.append = 1'b1;
                end else begin
                  fail = 1'b1;
                end
              end
              MD_QUOTE: begin
                if (sts_i.quo) begin
                  fail = sts_i.full;
                  cmd.append = 1'b1;
                  mode_d = MD_STRING;
                end else if (sts_i.sp) begin
                  t_en_d = 1'b1;
                  t_kind_d = K_STRING;
                  cmd.clr_len = 1'b1;
                  mode_d = MD_START;
                end else begin
                  fail = 1'b1;
                end
              end
              default: fail = 1'b1;
            endcase
            cmd.adv = 1'b1;
          end
          cmd.capture = 1'b1;
          cmd.col_cur = fail || eq_start;
          if (fail) begin
            cmd.append = 1'b0;
            cmd.clr_len = 1'b0;
            cmd.set_start = 1'b0;
            cmd.adv = 1'b0;
            cmd.reset_pos = 1'b0;
            mode_d = MD_ERR;
            t_en_d = 1'b0;
            s1_en_d = 1'b1;
            s1_kind_d = K_ERROR;
            s2_en_d = 1'b0;
          end
          if (t_en_d) begin
            state_d = ST_TXT_RD;
          end else if (s1_en_d) begin
            state_d = ST_S1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TXT_RD: state_d = ST_TXT_WR;
      ST_TXT_WR: begin
        if (ofree) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = t_kind_q;
          cmd.out_text = sts_i.emit_len != '0;
          cmd.out_last = tlast;
          if (tlast) begin
            state_d = s1_en_q ? ST_S1 : ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = ST_TXT_RD;
          end
        end
      end
      ST_S1: begin
        if (ofree) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = s1_kind_q;
          cmd.out_last = 1'b1;
          state_d = s2_en_q ? ST_S2 : ST_IDLE;
        end
      end
      ST_S2: begin
        if (ofree) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = s2_kind_q;
          cmd.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MD_START;
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      t_en_q <= 1'b0;
      t_kind_q <= K_ERROR;
      s1_en_q <= 1'b0;
      s1_kind_q <= K_ERROR;
      s2_en_q <= 1'b0;
      s2_kind_q <= K_ERROR;
    end else begin
      mode_q <= mode_d;
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      idx_q <= idx_d;
      t_en_q <= t_en_d;
      t_kind_q <= t_kind_d;
      s1_en_q <= s1_en_d;
      s1_kind_q <= s1_kind_d;
      s2_en_q <= s2_en_d;
      s2_kind_q <= s2_kind_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o = cmd;

  `KCL_ASSERT_NEXT(a_dead_stays_idle, mode_q == MD_ERR && state_q == ST_IDLE,
                   state_q == ST_IDLE && mode_q == MD_ERR, "Lexer left the error state.")
  `KCL_ASSERT(a_idx_in_range, state_q == ST_TXT_RD |-> (sts_i.emit_len == '0 || LenW'(idx_q) < sts_i.emit_len),
              "Text read index beyond token length.")
  `KCL_ASSERT(a_load_when_free, cmd.out_load |-> (!out_valid_q || out_ready_i),
              "Result register overwritten before its transfer.")

endmodule

// File: rtl/keyword_config_lexer_top.sv
// Top level of the keyword configuration lexer.
`timescale 1ns / 1ps
// The lexer takes one byte or end-of-input mark per input transfer and gives
// tokens one result per output transfer. It handles one item at a time: an item
// that gives no result is done once accepted; an item that gives results is
// accepted, then for each text byte of an integer or string the block first
// reads the text store and then loads the result register, then it loads each
// single result in turn, waiting while the output stalls. A result waiting in
// the output register does not block the next input transfer. After an error
// result the block takes every item silently until reset.
module keyword_config_lexer_top import kcl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  kcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kcl_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
